[rtl/indexed_list_store_defines.svh]
// Assertion macros shared by the indexed list store RTL.
`ifndef INDEXED_LIST_STORE_DEFINES_SVH
`define INDEXED_LIST_STORE_DEFINES_SVH

`ifndef SYNTHESIS

// Check a property every cycle out of reset.
`define ILS_CHECK(lbl, prop) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (prop)) \
	else $error("indexed_list_store assertion failed");

// Check that a condition implies another in the next cycle.
`define ILS_CHECK_NEXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
	else $error("indexed_list_store assertion failed");

`else

`define ILS_CHECK(lbl, prop)
`define ILS_CHECK_NEXT(lbl, ante, cons)

`endif

`endif

[rtl/ils_pkg.sv]
// Types, codes and sizes shared by the indexed list store modules.
`default_nettype none

package ils_pkg;

	localparam int CAPACITY   = 16;
	localparam int DATA_WIDTH = 32;
	localparam int IDX_W      = $clog2(CAPACITY);
	localparam int CNT_W      = $clog2(CAPACITY + 1);
	// compare width that holds both the request index and the count
	localparam int CMP_W      = (CNT_W > 5) ? CNT_W : 5;

	// request kinds
	typedef enum logic [2:0] {
		K_INSERT   = 3'd0,
		K_APPEND   = 3'd1,
		K_DEL_AT   = 3'd2,
		K_DEL_LAST = 3'd3,
		K_UPDATE   = 3'd4,
		K_READ     = 3'd5
	} kind_t;

	// result status
	typedef enum logic [1:0] {
		ST_OK    = 2'd0,
		ST_RANGE = 2'd1,
		ST_EMPTY = 2'd2,
		ST_FULL  = 2'd3
	} status_t;

	// action broadcast to every cell
	typedef enum logic [2:0] {
		ACT_NONE,
		ACT_INSERT,
		ACT_DELETE,
		ACT_WRITE,
		ACT_READ
	} cell_act_t;

	typedef struct packed {
		logic        [2:0]  kind;
		logic        [4:0]  index;
		logic signed [31:0] value;
	} req_t;

	typedef struct packed {
		logic signed [31:0] read_value;
		logic        [1:0]  status;
		logic        [4:0]  length;
	} rsp_t;

	typedef struct packed {
		cell_act_t             act;
		logic [IDX_W-1:0]      pos;
		logic [DATA_WIDTH-1:0] word;
	} cell_cmd_t;

endpackage

`default_nettype wire

[rtl/ils_cell.sv]
// One list position: holds its word and shifts with its neighbors.
`default_nettype none

module ils_cell
	import ils_pkg::*;
(
	input  wire logic                  clk,
	input  wire logic [IDX_W-1:0]      my_pos,
	input  wire cell_cmd_t             cmd,
	input  wire logic [DATA_WIDTH-1:0] left_data,
	input  wire logic [DATA_WIDTH-1:0] right_data,
	output logic      [DATA_WIDTH-1:0] data,
	output logic      [DATA_WIDTH-1:0] rd_data
);

	logic [DATA_WIDTH-1:0] data_q;
	logic [DATA_WIDTH-1:0] data_nxt;

	// pick the next word: hold, load, or take from a neighbor
	always_comb begin
		data_nxt = data_q;
		case (cmd.act)
			ACT_INSERT: begin
				if (my_pos == cmd.pos) begin
					data_nxt = cmd.word;
				end else if (my_pos > cmd.pos) begin
					data_nxt = left_data;
				end
			end
			ACT_DELETE: begin
				if (my_pos >= cmd.pos) begin
					data_nxt = right_data;
				end
			end
			ACT_WRITE: begin
				if (my_pos == cmd.pos) begin
					data_nxt = cmd.word;
				end
			end
			default: begin
				data_nxt = data_q;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		data_q <= data_nxt;
	end

	assign data = data_q;

	// drive the shared read bus only when addressed
	assign rd_data = (cmd.act == ACT_READ && my_pos == cmd.pos) ? data_q : '0;

endmodule

`default_nettype wire

[rtl/indexed_list_store.sv]
// Top level of the indexed list store: request decode, count and a row of cells.
//
//  channel | signals                  | moves
//  --------+--------------------------+-------------------------------------
//  req     | req_valid, req_ready,req | kind, index, value per transfer
//  rsp     | rsp_valid, rsp_ready,rsp | read_value, status, length
//
// Every request is decoded and applied to the cell row in the cycle it is
// taken; all cells shift in parallel, so one request per cycle is accepted unless a result stalls.
// The result appears in the output register the next cycle.
// A new request is taken whenever the output register is empty or is being
// drained in the same cycle; a stalled result blocks only further requests.
// Reset clears the count and the output valid; stored words stay undefined.
`default_nettype none

module indexed_list_store
	import ils_pkg::*;
(
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic req_valid,
	output logic      req_ready,
	input  wire req_t req,
	output logic      rsp_valid,
	input  wire logic rsp_ready,
	output rsp_t      rsp
);

	`include "indexed_list_store_defines.svh"

	logic                  take;
	logic [CNT_W-1:0]      count_q;
	logic [CNT_W-1:0]      count_nxt;
	logic [CMP_W-1:0]      idx_c;
	logic [CMP_W-1:0]      cnt_c;
	logic                  full_c;
	cell_act_t             act_c;
	status_t               st_c;
	logic [IDX_W-1:0]      pos_c;
	cell_cmd_t             cmd;
	logic [DATA_WIDTH-1:0] cell_data [CAPACITY];
	logic [DATA_WIDTH-1:0] cell_rd   [CAPACITY];
	logic [DATA_WIDTH-1:0] rd_word;
	rsp_t                  rsp_q;
	logic                  rsp_valid_q;

	assign req_ready = !rsp_valid_q || rsp_ready;
	assign take      = req_valid && req_ready;

	assign idx_c  = CMP_W'(req.index);
	assign cnt_c  = CMP_W'(count_q);
	assign full_c = (count_q == CNT_W'(CAPACITY));

	// decode the request against the current length
	always_comb begin
		act_c     = ACT_NONE;
		st_c      = ST_OK;
		count_nxt = count_q;
		pos_c     = idx_c[IDX_W-1:0];
		case (req.kind)
			K_INSERT: begin
				if (idx_c > cnt_c) begin
					st_c = ST_RANGE;
				end else if (full_c) begin
					st_c = ST_FULL;
				end else begin
					act_c     = ACT_INSERT;
					count_nxt = count_q + CNT_W'(1);
				end
			end
			K_APPEND: begin
				pos_c = cnt_c[IDX_W-1:0];
				if (full_c) begin
					st_c = ST_FULL;
				end else begin
					act_c     = ACT_INSERT;
					count_nxt = count_q + CNT_W'(1);
				end
			end
			K_DEL_AT: begin
				if (idx_c == '0 && count_q == '0) begin
					st_c = ST_EMPTY;
				end else if (idx_c >= cnt_c) begin
					st_c = ST_RANGE;
				end else begin
					act_c     = ACT_DELETE;
					count_nxt = count_q - CNT_W'(1);
				end
			end
			K_DEL_LAST: begin
				if (count_q == '0) begin
					st_c = ST_EMPTY;
				end else begin
					count_nxt = count_q - CNT_W'(1);
				end
			end
			K_UPDATE: begin
				if (idx_c >= cnt_c) begin
					st_c = ST_RANGE;
				end else begin
					act_c = ACT_WRITE;
				end
			end
			K_READ: begin
				if (idx_c >= cnt_c) begin
					st_c = ST_RANGE;
				end else begin
					act_c = ACT_READ;
				end
			end
			default: begin
				act_c = ACT_NONE;
			end
		endcase
	end

	// broadcast to the row only on a transfer
	always_comb begin
		cmd.act  = take ? act_c : ACT_NONE;
		cmd.pos  = pos_c;
		cmd.word = DATA_WIDTH'($unsigned(req.value));
	end

	// row of cells, each wired to its neighbors
	for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
		logic [DATA_WIDTH-1:0] left_w;
		logic [DATA_WIDTH-1:0] right_w;

		if (i == 0) begin : g_first
			assign left_w = '0;
		end else begin : g_mid_l
			assign left_w = cell_data[i-1];
		end

		if (i == CAPACITY - 1) begin : g_last
			assign right_w = cell_data[i];
		end else begin : g_mid_r
			assign right_w = cell_data[i+1];
		end

		ils_cell u_cell (
			.clk        (clk),
			.my_pos     (IDX_W'(i)),
			.cmd        (cmd),
			.left_data  (left_w),
			.right_data (right_w),
			.data       (cell_data[i]),
			.rd_data    (cell_rd[i])
		);
	end

	// merge the read bus; at most one cell drives it
	always_comb begin
		rd_word = '0;
		for (int i = 0; i < CAPACITY; i++) begin
			rd_word = rd_word | cell_rd[i];
		end
	end

	// advance the length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (take) begin
			count_q <= count_nxt;
		end
	end

	// hold the result until it is taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (take) begin
			rsp_valid_q <= 1'b1;
		end else if (rsp_ready) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take) begin
			rsp_q.read_value <= 32'(rd_word);
			rsp_q.status     <= st_c;
			rsp_q.length     <= 5'(count_nxt);
		end
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	`ILS_CHECK(a_count_bound, count_q <= CNT_W'(CAPACITY))
	`ILS_CHECK_NEXT(a_insert_grows, take && act_c == ACT_INSERT, count_q == $past(count_q) + CNT_W'(1))
	`ILS_CHECK(a_full_len, !rsp_valid_q || rsp_q.status != ST_FULL || rsp_q.length == 5'(CAPACITY))
	`ILS_CHECK(a_fail_zero, !rsp_valid_q || rsp_q.status == ST_OK || rsp_q.read_value == '0)
	`ILS_CHECK_NEXT(a_take_result, take, rsp_valid_q)

endmodule

`default_nettype wire

[bench/ils_tb_pkg.sv]
// List mirror for the indexed list store bench: predicts and checks every response.
package ils_tb_pkg;
	import ils_pkg::*;

	class list_mirror;
		logic [DATA_WIDTH-1:0] words [CAPACITY];
		int unsigned fill;
		rsp_t due_responses [$];
		int errors;
		int kind_seen [8];
		int status_seen [4];
		int unsigned peak;

		function new();
			fill = 0;
			errors = 0;
			peak = 0;
			foreach (kind_seen[i]) kind_seen[i] = 0;
			foreach (status_seen[i]) status_seen[i] = 0;
		endfunction

		// shift the tail up by one and place the word at pos
		function void open_gap(int unsigned pos, logic [31:0] word);
			for (int unsigned i = fill; i > pos; i--)
				words[i] = words[i - 1];
			words[pos] = word[DATA_WIDTH-1:0];
			fill++;
		endfunction

		// shift the tail down by one over pos
		function void close_gap(int unsigned pos);
			for (int unsigned i = pos; i + 1 < fill; i++)
				words[i] = words[i + 1];
			fill--;
		endfunction

		// apply one accepted request and queue the response it must produce
		function void apply_request(req_t r);
			rsp_t want;
			want = '0;
			want.status = ST_OK;
			case (r.kind)
			K_INSERT: begin
				if (r.index > fill)
					want.status = ST_RANGE;
				else if (fill >= CAPACITY)
					want.status = ST_FULL;
				else
					open_gap(r.index, r.value);
			end
			K_APPEND: begin
				if (fill >= CAPACITY)
					want.status = ST_FULL;
				else
					open_gap(fill, r.value);
			end
			K_DEL_AT: begin
				if (r.index == 0 && fill == 0)
					want.status = ST_EMPTY;
				else if (r.index >= fill)
					want.status = ST_RANGE;
				else
					close_gap(r.index);
			end
			K_DEL_LAST: begin
				if (fill == 0)
					want.status = ST_EMPTY;
				else
					fill--;
			end
			K_UPDATE: begin
				if (r.index >= fill)
					want.status = ST_RANGE;
				else
					words[r.index] = r.value[DATA_WIDTH-1:0];
			end
			K_READ: begin
				if (r.index >= fill)
					want.status = ST_RANGE;
				else
					want.read_value = 32'(words[r.index]);
			end
			default: begin
				// spare kinds leave the list alone
			end
			endcase
			want.length = 5'(fill);
			kind_seen[r.kind]++;
			status_seen[want.status]++;
			if (fill > peak)
				peak = fill;
			due_responses.push_back(want);
		endfunction

		// compare one response transfer with the oldest prediction
		function void check_response(rsp_t got, time at);
			rsp_t want;
			if (due_responses.size() == 0) begin
				$display("%0d ns: response with none pending, expected nothing actual %h",
					at, got);
				errors++;
				return;
			end
			want = due_responses.pop_front();
			if (got.read_value !== want.read_value) begin
				$display("%0d ns: read_value expected %h actual %h",
					at, want.read_value, got.read_value);
				errors++;
			end
			if (got.status !== want.status) begin
				$display("%0d ns: status expected %0d actual %0d", at, want.status, got.status);
				errors++;
			end
			if (got.length !== want.length) begin
				$display("%0d ns: length expected %0d actual %0d", at, want.length, got.length);
				errors++;
			end
		endfunction
	endclass

endpackage

[bench/tb_top.sv]
// Top of the indexed list store bench: clock, reset, request and response drivers.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;

	import ils_pkg::*;
	import ils_tb_pkg::*;

	localparam int ITEMS = 450;
	// kinds the block decodes as no-ops
	localparam logic [2:0] KIND_SPARE_LO = 3'd6;
	localparam logic [2:0] KIND_SPARE_HI = 3'd7;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic req_valid = 1'b0;
	logic req_ready;
	req_t req = '0;
	logic rsp_valid;
	logic rsp_ready = 1'b0;
	rsp_t rsp;

	list_mirror mirror;
	int tx_idle_pct = 0;
	int rx_idle_pct = 0;
	int hold_left = 0;
	bit grow = 1'b1;

	indexed_list_store DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req_valid),
		.req_ready (req_ready),
		.req       (req),
		.rsp_valid (rsp_valid),
		.rsp_ready (rsp_ready),
		.rsp       (rsp)
	);

	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// stop a hung run
	initial begin
		#1ms;
		$display("Verification failed");
		$finish;
	end

	function automatic req_t mk(logic [2:0] k, logic [4:0] at, logic [31:0] v);
		req_t r;
		r.kind = k;
		r.index = at;
		r.value = v;
		return r;
	endfunction

	// random request, biased to grow the list to full and then drain it to empty
	function automatic req_t pick_request();
		req_t r;
		int roll;
		int unsigned n;
		n = mirror.fill;
		if (n >= CAPACITY && $urandom_range(3) == 0)
			grow = 1'b0;
		if (n == 0 && $urandom_range(3) == 0)
			grow = 1'b1;
		if ($urandom_range(99) < 3) begin
			r.kind = $urandom_range(1) ? KIND_SPARE_HI : KIND_SPARE_LO;
		end else begin
			roll = $urandom_range(99);
			if (roll < (grow ? 35 : 10))
				r.kind = K_INSERT;
			else if (roll < (grow ? 60 : 20))
				r.kind = K_APPEND;
			else if (roll < (grow ? 70 : 50))
				r.kind = K_DEL_AT;
			else if (roll < (grow ? 75 : 70))
				r.kind = K_DEL_LAST;
			else if (roll < 87)
				r.kind = K_UPDATE;
			else
				r.kind = K_READ;
		end
		if ($urandom_range(99) < 15)
			r.index = 5'($urandom_range(31));
		else if (r.kind == K_INSERT)
			r.index = 5'($urandom_range(n));
		else if (n > 0)
			r.index = 5'($urandom_range(n - 1));
		else
			r.index = '0;
		case ($urandom_range(19))
		0: r.value = 32'h8000_0000;
		1: r.value = 32'h7fff_ffff;
		2: r.value = 32'h0000_0000;
		3: r.value = 32'hffff_ffff;
		default: r.value = $urandom;
		endcase
		return r;
	endfunction

	// offer one request after a random gap and hold it until the transfer
	task automatic send_request(req_t item);
		int gap;
		gap = 0;
		while (gap < 40 && $urandom_range(99) < tx_idle_pct)
			gap++;
		if (gap > 0) begin
			req_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		req_valid <= 1'b1;
		req <= item;
		do @(posedge clk); while (req_ready !== 1'b1);
		mirror.apply_request(item);
	endtask

	// stop offering and wait for every pending response
	task automatic wait_idle();
		req_valid <= 1'b0;
		do @(posedge clk); while (mirror.due_responses.size() != 0);
	endtask

	task automatic run_random(int n);
		req_t item;
		int sent;
		sent = 0;
		while (sent < n) begin
			item = pick_request();
			send_request(item);
			if (item.kind <= K_READ)
				sent++;
		end
	endtask

	// response side: check each transfer, then pick ready for the next edge
	initial begin
		forever begin
			@(posedge clk);
			if (rsp_valid === 1'b1 && rsp_ready)
				mirror.check_response(rsp, $time);
			if (hold_left > 0) begin
				rsp_ready <= 1'b0;
				hold_left--;
			end else begin
				rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	initial begin
		req_t directed [$];
		mirror = new();
		tx_idle_pct = 9;
		rx_idle_pct = 77;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// empty list corners, spare kinds, word extremes, shifts both ways
		directed = '{
			mk(K_READ, 5'd0, 32'h0), mk(K_UPDATE, 5'd0, 32'h1234_5678),
			mk(K_DEL_AT, 5'd0, 32'h0), mk(K_DEL_AT, 5'd1, 32'h0),
			mk(K_DEL_LAST, 5'd0, 32'h0), mk(K_INSERT, 5'd1, 32'h1),
			mk(KIND_SPARE_LO, 5'd0, 32'h0), mk(KIND_SPARE_HI, 5'd31, 32'hffff_ffff),
			mk(K_INSERT, 5'd0, 32'h8000_0000), mk(K_APPEND, 5'd0, 32'h7fff_ffff),
			mk(K_INSERT, 5'd1, 32'hffff_ffff), mk(K_INSERT, 5'd3, 32'h0000_0000),
			mk(K_INSERT, 5'd5, 32'h2), mk(K_READ, 5'd0, 32'h0),
			mk(K_READ, 5'd1, 32'h0), mk(K_READ, 5'd2, 32'h0),
			mk(K_READ, 5'd3, 32'h0), mk(K_READ, 5'd31, 32'h0),
			mk(K_UPDATE, 5'd2, 32'h5555_5555), mk(K_READ, 5'd2, 32'h0),
			mk(K_DEL_AT, 5'd1, 32'h0), mk(K_DEL_AT, 5'd3, 32'h0),
			mk(K_DEL_LAST, 5'd0, 32'h0), mk(K_READ, 5'd1, 32'h0)
		};
		foreach (directed[i])
			send_request(directed[i]);
		run_random(ITEMS / 3);
		wait_idle();

		// swap the idling between the two sides
		tx_idle_pct = 77;
		rx_idle_pct = 9;
		run_random(ITEMS / 3);
		wait_idle();

		// no idling; open with a long response stall so the input backs up
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		hold_left = 40;
		run_random(ITEMS / 3);
		wait_idle();
		repeat (8) @(posedge clk);

		$display("Requests: %0d ins, %0d app, %0d del-at, %0d del-last, %0d upd, %0d rd, %0d spare",
			mirror.kind_seen[K_INSERT], mirror.kind_seen[K_APPEND],
			mirror.kind_seen[K_DEL_AT], mirror.kind_seen[K_DEL_LAST],
			mirror.kind_seen[K_UPDATE], mirror.kind_seen[K_READ],
			mirror.kind_seen[KIND_SPARE_LO] + mirror.kind_seen[KIND_SPARE_HI]);
		$display("Outcomes: %0d ok, %0d out of range, %0d empty, %0d full; longest list %0d",
			mirror.status_seen[ST_OK], mirror.status_seen[ST_RANGE],
			mirror.status_seen[ST_EMPTY], mirror.status_seen[ST_FULL], mirror.peak);
		if (mirror.errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
